// File: hdl/base64_decoder_alt_alphabet_unit_defines.svh
// Assertion macros shared by the base64 decoder RTL.
`ifndef BASE64_DECODER_ALT_ALPHABET_UNIT_DEFINES_SVH
`define BASE64_DECODER_ALT_ALPHABET_UNIT_DEFINES_SVH

// Checks that a property holds at every rising clock edge outside reset.
`define B64ALT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define B64ALT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/b64alt_pkg.sv
// Types, constants and the symbol decode and total clamp functions of the base64 decoder.
`default_nettype none
package b64alt_pkg;

   localparam int COUNT_BITS = 16;
   localparam int CHAR_BITS = 16;
   localparam int BYTE_BITS = 8;
   localparam int TOTAL_BITS = 16;
   localparam int SYM_BITS = 6;
   localparam int ACC_BITS = 12;
   localparam int PHASE_BITS = 2;

   localparam logic [CHAR_BITS-1:0] CHAR_NUL = 16'h0000;
   localparam logic [CHAR_BITS-1:0] CHAR_PAD = 16'h003D;
   localparam logic [CHAR_BITS-1:0] CHAR_UP_A = 16'h0041;
   localparam logic [CHAR_BITS-1:0] CHAR_UP_Z = 16'h005A;
   localparam logic [CHAR_BITS-1:0] CHAR_LO_A = 16'h0061;
   localparam logic [CHAR_BITS-1:0] CHAR_LO_Z = 16'h007A;
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO = 16'h0030;
   localparam logic [CHAR_BITS-1:0] CHAR_NINE = 16'h0039;
   localparam logic [CHAR_BITS-1:0] CHAR_PLUS = 16'h002B;
   localparam logic [CHAR_BITS-1:0] CHAR_BANG = 16'h0021;
   localparam logic [CHAR_BITS-1:0] CHAR_SLASH = 16'h002F;
   localparam logic [CHAR_BITS-1:0] CHAR_STAR = 16'h002A;

   localparam logic [SYM_BITS-1:0] SYM_LO_BASE = 6'd26;
   localparam logic [SYM_BITS-1:0] SYM_DIGIT_BASE = 6'd52;
   localparam logic [SYM_BITS-1:0] SYM_62 = 6'd62;
   localparam logic [SYM_BITS-1:0] SYM_63 = 6'd63;

   localparam logic [PHASE_BITS-1:0] PHASE_FIRST = 2'd0;
   localparam logic [PHASE_BITS-1:0] PHASE_SECOND = 2'd1;
   localparam logic [PHASE_BITS-1:0] PHASE_THIRD = 2'd2;
   localparam logic [PHASE_BITS-1:0] PHASE_FOURTH = 2'd3;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   typedef struct packed {
      logic                  is_symbol;
      logic [SYM_BITS-1:0]   value;
   } symbol_type;

   typedef struct packed {
      logic                  valid;
      logic [BYTE_BITS-1:0]  out_byte;
      logic                  is_end;
      logic [TOTAL_BITS-1:0] total_bytes;
   } result_type;

   // Maps a character code to its six-bit symbol value.
   function automatic symbol_type decode_symbol(input logic [CHAR_BITS-1:0] c);
      symbol_type s;
      logic [CHAR_BITS-1:0] d;
      s = '{is_symbol: 1'b1, value: '0};
      d = '0;
      case (c) inside
         [CHAR_UP_A:CHAR_UP_Z]: begin
            d = c - CHAR_UP_A;
            s.value = d[SYM_BITS-1:0];
         end
         [CHAR_LO_A:CHAR_LO_Z]: begin
            d = c - CHAR_LO_A;
            s.value = d[SYM_BITS-1:0] + SYM_LO_BASE;
         end
         [CHAR_ZERO:CHAR_NINE]: begin
            d = c - CHAR_ZERO;
            s.value = d[SYM_BITS-1:0] + SYM_DIGIT_BASE;
         end
         CHAR_PLUS, CHAR_BANG: s.value = SYM_62;
         CHAR_SLASH, CHAR_STAR: s.value = SYM_63;
         default: s.is_symbol = 1'b0;
      endcase
      return s;
   endfunction

   // Clamps the running byte count to the width of the total field.
   function automatic logic [TOTAL_BITS-1:0] clamp_total(input logic [COUNT_BITS-1:0] n);
      logic [63:0] wide;
      wide = 64'(n);
      if (wide > 64'({TOTAL_BITS{1'b1}})) begin
         return {TOTAL_BITS{1'b1}};
      end
      return wide[TOTAL_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

// File: hdl/b64alt_core.sv
// Decode state and per-word result logic of the base64 decoder.
`default_nettype none
module b64alt_core
   import b64alt_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire logic [CHAR_BITS-1:0] char_code,
   output result_type                result
);

   logic [ACC_BITS-1:0]   acc_ff, acc_in;
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   symbol_type          sym;
   logic                is_term;
   logic [ACC_BITS-1:0] acc_next;

   assign sym = decode_symbol(char_code);
   assign is_term = (char_code == CHAR_NUL) || (char_code == CHAR_PAD);
   assign acc_next = {acc_ff[ACC_BITS-SYM_BITS-1:0], sym.value};

   always_comb begin
      acc_in = acc_ff;
      phase_in = phase_ff;
      count_in = count_ff;
      result = '0;
      if (is_term) begin
         result.valid = 1'b1;
         result.is_end = 1'b1;
         result.total_bytes = clamp_total(count_ff);
         acc_in = '0;
         phase_in = PHASE_FIRST;
         count_in = '0;
      end else if (sym.is_symbol) begin
         acc_in = acc_next;
         phase_in = phase_ff + 2'd1;
         if (phase_ff != PHASE_FIRST) begin
            result.valid = 1'b1;
            if (count_ff != COUNT_MAX) begin
               count_in = count_ff + 1'b1;
            end
         end
         // The byte sits lower in the accumulator as the group fills.
         case (phase_ff)
            PHASE_SECOND: result.out_byte = acc_next[11:4];
            PHASE_THIRD: result.out_byte = acc_next[9:2];
            PHASE_FOURTH: result.out_byte = acc_next[7:0];
            default: result.out_byte = '0;
         endcase
         if (phase_ff == PHASE_FIRST) begin
            result.out_byte = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         phase_ff <= PHASE_FIRST;
         count_ff <= '0;
      end else if (step) begin
         acc_ff <= acc_in;
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

// File: hdl/base64_decoder_alt_alphabet_unit.sv
// Top level of the base64 decoder: input register, decode core, result register.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | req_char_code
//   rsp     | out       | rsp_valid/rsp_stall | rsp_out_byte, rsp_is_end, rsp_total_bytes
//
// One word is taken every cycle while req_stall is low; a word that yields a result
// passes through the input register and the result register before it is offered.
// Reset is synchronous and clears the decode state and both valid flags.
// A stalled result holds the input register only when it holds a word; stall on the
// result side reaches req_stall in the same cycle.
`default_nettype none
`include "base64_decoder_alt_alphabet_unit_defines.svh"
module base64_decoder_alt_alphabet_unit
   import b64alt_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [CHAR_BITS-1:0]  req_char_code,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [BYTE_BITS-1:0]       rsp_out_byte,
   output logic                       rsp_is_end,
   output logic [TOTAL_BITS-1:0]      rsp_total_bytes
);

   logic                 in_valid_ff, in_valid_in;
   logic [CHAR_BITS-1:0] in_char_ff;
   logic                 out_valid_ff, out_valid_in;
   result_type           out_ff;
   result_type           core_result;
   logic                 out_open;
   logic                 step;
   logic                 req_take;

   assign out_open = !out_valid_ff || !rsp_stall;
   assign step = in_valid_ff && out_open;
   assign req_stall = in_valid_ff && !out_open;
   assign req_take = req_valid && !req_stall;

   b64alt_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .char_code (in_char_ff),
      .result    (core_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (out_open) begin
         out_valid_in = step && core_result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_char_code;
      end
      if (step && core_result.valid) begin
         out_ff <= core_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_out_byte = out_ff.out_byte;
   assign rsp_is_end = out_ff.is_end;
   assign rsp_total_bytes = out_ff.total_bytes;

   `B64ALT_ASSERT(a_stall_needs_word, !req_stall || in_valid_ff, "stall without a held word")
   `B64ALT_ASSERT(a_byte_has_no_total,
      !(rsp_valid && !rsp_is_end) || rsp_total_bytes == '0, "decoded byte carries a total")
   `B64ALT_ASSERT(a_end_has_no_byte,
      !(rsp_valid && rsp_is_end) || rsp_out_byte == '0, "end marker carries a byte")
   `B64ALT_ASSERT_NEXT(a_result_held, rsp_valid && rsp_stall,
      rsp_valid && $stable(out_ff), "stalled result changed")

endmodule
`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for the base64 decoder with the alternate alphabet.
module tb
   import b64alt_pkg::*;
();

   localparam int LIMIT_CYCLES = 500000;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int DRAIN_CYCLES = 8;
   localparam int STRING_QUOTA = 650;

   localparam logic [CHAR_BITS-1:0] DIRECTED_CHARS [25] = '{
      CHAR_PAD,
      CHAR_UP_A, CHAR_UP_Z, CHAR_LO_A, CHAR_LO_Z,
      CHAR_ZERO, CHAR_NINE, CHAR_PLUS, CHAR_BANG,
      CHAR_SLASH, CHAR_STAR, CHAR_PAD,
      16'h0051, CHAR_NUL,
      CHAR_NUL,
      16'hFFFF, 16'h0080, CHAR_UP_A, 16'h0040, 16'h005B,
      16'h0060, 16'h007B, CHAR_LO_Z, 16'h0141, CHAR_PAD
   };

   typedef struct packed {
      logic [BYTE_BITS-1:0]  out_byte;
      logic                  is_end;
      logic [TOTAL_BITS-1:0] total_bytes;
   } decoded_word_type;

   class decode_tracker_type;
      logic [ACC_BITS-1:0]   acc;
      logic [PHASE_BITS-1:0] phase;
      logic [COUNT_BITS-1:0] byte_count;
      decoded_word_type      expected_q[$];
      int                    fail_count;

      function new();
         acc = '0;
         phase = PHASE_FIRST;
         byte_count = '0;
         fail_count = 0;
      endfunction

      static function bit char_to_sextet(input logic [CHAR_BITS-1:0] c,
                                         output logic [SYM_BITS-1:0] v);
         logic [CHAR_BITS-1:0] d;
         d = '0;
         v = '0;
         if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
            d = c - CHAR_UP_A;
         end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
            d = c - CHAR_LO_A + CHAR_BITS'(SYM_LO_BASE);
         end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d = c - CHAR_ZERO + CHAR_BITS'(SYM_DIGIT_BASE);
         end else if (c == CHAR_PLUS || c == CHAR_BANG) begin
            d = CHAR_BITS'(SYM_62);
         end else if (c == CHAR_SLASH || c == CHAR_STAR) begin
            d = CHAR_BITS'(SYM_63);
         end else begin
            return 1'b0;
         end
         v = d[SYM_BITS-1:0];
         return 1'b1;
      endfunction

      // Advances the decode state by one accepted word and queues what it yields.
      function void decode_char(input logic [CHAR_BITS-1:0] c);
         logic [SYM_BITS-1:0] v;
         decoded_word_type w;
         w = '0;
         if (c == CHAR_NUL || c == CHAR_PAD) begin
            w.is_end = 1'b1;
            if (64'(byte_count) > 64'({TOTAL_BITS{1'b1}}))
               w.total_bytes = {TOTAL_BITS{1'b1}};
            else
               w.total_bytes = TOTAL_BITS'(byte_count);
            expected_q.push_back(w);
            acc = '0;
            phase = PHASE_FIRST;
            byte_count = '0;
            return;
         end
         if (!char_to_sextet(c, v))
            return;
         acc = {acc[ACC_BITS-SYM_BITS-1:0], v};
         if (phase != PHASE_FIRST) begin
            case (phase)
               PHASE_SECOND: w.out_byte = acc[11:4];
               PHASE_THIRD: w.out_byte = acc[9:2];
               default: w.out_byte = acc[7:0];
            endcase
            expected_q.push_back(w);
            if (byte_count != COUNT_MAX)
               byte_count = byte_count + 1'b1;
         end
         phase = phase + 1'b1;
      endfunction

      function void check_output(input logic [BYTE_BITS-1:0] out_byte, input logic is_end,
                                 input logic [TOTAL_BITS-1:0] total_bytes);
         decoded_word_type w;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected word: byte %02h end %0b total %0d", $time,
                     out_byte, is_end, total_bytes);
            fail_count++;
            return;
         end
         w = expected_q.pop_front();
         if (out_byte !== w.out_byte) begin
            $display("%0t: out_byte expected %02h actual %02h", $time, w.out_byte, out_byte);
            fail_count++;
         end
         if (is_end !== w.is_end) begin
            $display("%0t: is_end expected %0b actual %0b", $time, w.is_end, is_end);
            fail_count++;
         end
         if (total_bytes !== w.total_bytes) begin
            $display("%0t: total_bytes expected %0d actual %0d", $time, w.total_bytes,
                     total_bytes);
            fail_count++;
         end
      endfunction

      function int pending_count();
         return expected_q.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [CHAR_BITS-1:0]  req_char_code = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [BYTE_BITS-1:0]  rsp_out_byte;
   logic                  rsp_is_end;
   logic [TOTAL_BITS-1:0] rsp_total_bytes;

   decode_tracker_type tracker = new();
   int send_idle_pct = 23;
   int recv_idle_pct = 69;
   int holdoff_asks = 0;
   int holdoff_seen = 0;
   int holdoff_left = 0;
   int cycle_count = 0;

   base64_decoder_alt_alphabet_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_char_code(req_char_code),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_is_end(rsp_is_end),
      .rsp_total_bytes(rsp_total_bytes)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("base64_decoder_alt_alphabet_unit test failed");
         $finish;
      end
   end

   // Receiver: random stalls, plus one long hold-off on request so the block backs up.
   always @(posedge clock) begin
      if (holdoff_left > 0) begin
         holdoff_left <= holdoff_left - 1;
         rsp_stall <= 1'b1;
      end else if (holdoff_asks != holdoff_seen) begin
         holdoff_seen <= holdoff_asks;
         holdoff_left <= HOLDOFF_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            tracker.decode_char(req_char_code);
         if (rsp_valid && !rsp_stall)
            tracker.check_output(rsp_out_byte, rsp_is_end, rsp_total_bytes);
      end
   end

   function automatic logic [CHAR_BITS-1:0] symbol_char(input logic [SYM_BITS-1:0] v);
      if (v < SYM_LO_BASE)
         return CHAR_UP_A + CHAR_BITS'(v);
      if (v < SYM_DIGIT_BASE)
         return CHAR_LO_A + CHAR_BITS'(v - SYM_LO_BASE);
      if (v < SYM_62)
         return CHAR_ZERO + CHAR_BITS'(v - SYM_DIGIT_BASE);
      if (v == SYM_62)
         return $urandom_range(1) ? CHAR_PLUS : CHAR_BANG;
      return $urandom_range(1) ? CHAR_SLASH : CHAR_STAR;
   endfunction

   // Offers one word and returns once it is taken; called at a rising edge.
   task automatic send_char(input logic [CHAR_BITS-1:0] c);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_char_code <= c;
      do @(posedge clock); while (req_stall);
   endtask

   // Mostly well-formed strings with random content, sprinkled with stray characters.
   task automatic send_random_strings(input int quota);
      int taken;
      int len;
      logic [CHAR_BITS-1:0] c;
      taken = 0;
      while (taken < quota) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(80) : $urandom_range(24);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 88)
               c = symbol_char(SYM_BITS'($urandom_range(63)));
            else if ($urandom_range(1) == 1)
               c = CHAR_BITS'($urandom);
            else
               c = CHAR_BITS'($urandom_range(127, 1));
            taken++;
            send_char(c);
         end
         send_char($urandom_range(1) ? CHAR_PAD : CHAR_NUL);
         taken++;
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_CHARS[i])
         send_char(DIRECTED_CHARS[i]);
      send_random_strings(STRING_QUOTA);

      send_idle_pct = 69;
      recv_idle_pct <= 23;
      send_random_strings(STRING_QUOTA);

      send_idle_pct = 0;
      recv_idle_pct <= 0;
      holdoff_asks <= holdoff_asks + 1;
      send_random_strings(STRING_QUOTA);

      req_valid <= 1'b0;
      while (tracker.pending_count() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.fail_count == 0)
         $display("base64_decoder_alt_alphabet_unit test passed");
      else
         $display("base64_decoder_alt_alphabet_unit test failed");
      $finish;
   end
endmodule

// File: filelist.f
+incdir+hdl
hdl/b64alt_pkg.sv
hdl/b64alt_core.sv
hdl/base64_decoder_alt_alphabet_unit.sv
sim/tb.sv
